[rtl/kabe_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// kabe_pkg
// Shared types, constants and helpers of the angle/bias Kalman estimator.
// ----------------------------------------------------------------------------
package kabe_pkg;

  localparam int unsigned ANGLE_FRAC_BITS = 16;
  localparam int unsigned COV_FRAC_BITS   = 24;
  localparam int unsigned DT_FRAC_BITS    = 16;

  localparam logic [1:0] CFG_Q_ANGLE = 2'd0;
  localparam logic [1:0] CFG_Q_BIAS  = 2'd1;
  localparam logic [1:0] CFG_R_MEAS  = 2'd2;

  localparam logic [31:0] Q_ANGLE_RST = 32'd16777;
  localparam logic [31:0] Q_BIAS_RST  = 32'd50332;
  localparam logic [31:0] R_MEAS_RST  = 32'd503316;

  // datapath operations, one per controller step
  // row-1 updates (C10, C11) run first so they see the predicted P00 and P01
  typedef enum logic [3:0] {
    OP_RATE   = 4'd0,
    OP_ANGP   = 4'd1,
    OP_T      = 4'd2,
    OP_P00P   = 4'd3,
    OP_PREST  = 4'd4,
    OP_DIVGO0 = 4'd5,
    OP_DIVGO1 = 4'd6,
    OP_Y      = 4'd7,
    OP_ANGC   = 4'd8,
    OP_BIASC  = 4'd9,
    OP_C10    = 4'd10,
    OP_C11    = 4'd11,
    OP_C00    = 4'd12,
    OP_C01    = 4'd13,
    OP_CLEAR  = 4'd14,
    OP_NONE   = 4'd15
  } op_t;

  typedef struct packed {
    logic load;
    op_t  op;
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
  } dp_sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) r = 32'sh7fffffff;
    else if (v < -66'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  // round to nearest, ties upward, arithmetic shift
  function automatic logic signed [65:0] rshr16(input logic signed [65:0] v);
    logic signed [65:0] t;
    t = v + (66'sd1 <<< (DT_FRAC_BITS - 1));
    return t >>> DT_FRAC_BITS;
  endfunction

  function automatic logic signed [65:0] rshr24(input logic signed [65:0] v);
    logic signed [65:0] t;
    t = v + (66'sd1 <<< (COV_FRAC_BITS - 1));
    return t >>> COV_FRAC_BITS;
  endfunction

endpackage
`default_nettype wire

[rtl/kalman_angle_bias_estimator_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// kalman_angle_bias_estimator_core
// Two-state angle/gyro-bias Kalman filter with saturating fixed point.
// ----------------------------------------------------------------------------
// channel | direction | payload
// in      | in        | action, new_angle, new_rate, time_step
// out     | out       | angle_estimate, bias_estimate
// cfg     | in        | cfg_index, cfg_data
// A sample runs the datapath steps in order, with the bit-serial divider run
// twice for the two gains; the result is then held in the output state until
// taken, and the core returns to idle. A clear zeroes the covariance.
// One word is processed at a time.
// Reset is synchronous, active low; it restores noise registers and zeroes state.
// The result word is held until taken; in_ready is low meanwhile.
// ----------------------------------------------------------------------------
module kalman_angle_bias_estimator_core
  import kabe_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_action,
  input  wire logic signed [31:0] in_new_angle,
  input  wire logic signed [31:0] in_new_rate,
  input  wire logic [15:0]        in_time_step,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_angle_estimate,
  output logic signed [31:0]      out_bias_estimate,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);
  logic [31:0] q_angle_r, q_bias_r, r_meas_r;
  logic        idle, acc;
  dp_cmd_t     cmd;
  dp_sts_t     sts;

  assign in_ready  = idle;
  assign cfg_ready = 1'b1;
  assign acc       = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_angle_r <= Q_ANGLE_RST;
      q_bias_r  <= Q_BIAS_RST;
      r_meas_r  <= R_MEAS_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_Q_ANGLE: q_angle_r <= cfg_data;
        CFG_Q_BIAS:  q_bias_r  <= cfg_data;
        CFG_R_MEAS:  r_meas_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  kabe_ctrl u_ctrl (.clk, .rst_n, .start(acc), .clear(in_action), .sts,
                    .out_ready, .cmd, .idle, .out_valid);

  kabe_datapath u_dp (.clk, .rst_n, .cmd, .sts, .in_load(acc),
                      .new_angle(in_new_angle), .new_rate(in_new_rate),
                      .time_step(in_time_step), .q_angle(q_angle_r),
                      .q_bias(q_bias_r), .r_meas(r_meas_r),
                      .angle_q(out_angle_estimate), .bias_q(out_bias_estimate));

`ifndef ASSERT_OFF
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("in_ready with result pending");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_angle_estimate) && $stable(out_bias_estimate))
    else $error("result changed while stalled");
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> !in_ready) else $error("accepted twice");
`endif
endmodule
`default_nettype wire

[rtl/kabe_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// kabe_div
// Radix-2 signed divider, 57-bit dividend by 34-bit divisor, truncating,
// saturated to 32 bits; zero divisor gives zero.
// ----------------------------------------------------------------------------
module kabe_div
  import kabe_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic signed [32:0]  num,
  input  wire logic signed [33:0]  den,
  output logic                     busy,
  output logic signed [31:0]       quo
);
  logic [5:0]  cnt_r, cnt_nxt;
  logic [56:0] q_r, q_nxt;
  logic [57:0] rem_r, rem_nxt;
  logic [33:0] d_r, d_nxt;
  logic        neg_r, neg_nxt, zero_r, zero_nxt;
  logic        busy_r, busy_nxt;
  logic [57:0] sh;
  logic signed [65:0] sq;

  always_comb begin
    cnt_nxt = cnt_r; q_nxt = q_r; rem_nxt = rem_r; d_nxt = d_r;
    neg_nxt = neg_r; zero_nxt = zero_r; busy_nxt = busy_r;
    sh = {rem_r[56:0], q_r[56]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 6'd57;
      q_nxt    = (num[32] ? 57'(-num) : 57'(num)) << COV_FRAC_BITS;
      rem_nxt  = '0;
      d_nxt    = den[33] ? 34'(-den) : 34'(den);
      neg_nxt  = num[32] ^ den[33];
      zero_nxt = (den == '0);
    end else if (busy_r) begin
      q_nxt = {q_r[55:0], 1'b0};
      if (sh >= {24'd0, d_r}) begin
        rem_nxt = sh - {24'd0, d_r};
        q_nxt[0] = 1'b1;
      end else begin
        rem_nxt = sh;
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r <= q_nxt; rem_r <= rem_nxt; d_r <= d_nxt;
    neg_r <= neg_nxt; zero_r <= zero_nxt;
  end

  assign sq   = neg_r ? -$signed({9'd0, q_r}) : $signed({9'd0, q_r});
  assign busy = busy_r;
  assign quo  = zero_r ? 32'sd0 : sat32(sq);
endmodule
`default_nettype wire

[rtl/kabe_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// kabe_datapath
// State, covariance and one shared multiplier; executes one op per command.
// ----------------------------------------------------------------------------
module kabe_datapath
  import kabe_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire dp_cmd_t            cmd,
  output dp_sts_t                 sts,
  input  wire logic               in_load,
  input  wire logic signed [31:0] new_angle,
  input  wire logic signed [31:0] new_rate,
  input  wire logic [15:0]        time_step,
  input  wire logic [31:0]        q_angle,
  input  wire logic [31:0]        q_bias,
  input  wire logic [31:0]        r_meas,
  output logic signed [31:0]      angle_q,
  output logic signed [31:0]      bias_q
);
  logic signed [31:0] ang_r, bias_r, p00_r, p01_r, p10_r, p11_r;
  logic signed [31:0] meas_r, rin_r, rate_r, t_r, k0_r, k1_r, y_r;
  logic [15:0] dt_r;
  logic signed [32:0] ma, dtp;
  logic signed [34:0] mb;
  logic signed [65:0] prod;
  logic signed [32:0] dnum;
  logic signed [33:0] dden;
  logic dstart, dbusy;
  logic signed [31:0] quo;

  assign dnum = cmd.op == OP_DIVGO0 ? 33'(p00_r) : 33'(p10_r);
  assign dden = 34'(p00_r) + $signed({2'b00, r_meas});
  assign dstart = cmd.load && (cmd.op == OP_DIVGO0 || cmd.op == OP_DIVGO1);

  kabe_div u_div (.clk, .rst_n, .start(dstart), .num(dnum), .den(dden),
                  .busy(dbusy), .quo);

  assign dtp = $signed({17'd0, dt_r});

  always_comb begin
    ma = dtp; mb = 35'(rate_r);
    unique case (cmd.op)
      OP_ANGP:  mb = 35'(rate_r);
      OP_T:     mb = 35'(p11_r);
      OP_P00P:  mb = 35'(66'(t_r) - 66'(p01_r) - 66'(p10_r) + $signed({34'd0, q_angle}));
      OP_PREST: mb = $signed({3'd0, q_bias});
      OP_ANGC:  begin ma = 33'(k0_r); mb = 35'(y_r); end
      OP_BIASC: begin ma = 33'(k1_r); mb = 35'(y_r); end
      OP_C00:   begin ma = 33'(k0_r); mb = 35'(p00_r); end
      OP_C01:   begin ma = 33'(k0_r); mb = 35'(p01_r); end
      OP_C10:   begin ma = 33'(k1_r); mb = 35'(p00_r); end
      OP_C11:   begin ma = 33'(k1_r); mb = 35'(p01_r); end
      default:  ;
    endcase
    prod = ma * mb;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ang_r <= '0; bias_r <= '0;
      p00_r <= '0; p01_r <= '0; p10_r <= '0; p11_r <= '0;
    end else begin
      if (in_load) begin
        meas_r <= new_angle; rin_r <= new_rate; dt_r <= time_step;
      end
      if (cmd.load) begin
        unique case (cmd.op)
          OP_RATE:  rate_r <= sat32(66'(rin_r) - 66'(bias_r));
          OP_ANGP:  ang_r <= sat32(66'(ang_r) + rshr16(prod));
          OP_T:     t_r <= 32'(rshr16(prod));
          OP_P00P:  p00_r <= sat32(66'(p00_r) + rshr16(prod));
          OP_PREST: begin
            p01_r <= sat32(66'(p01_r) - 66'(t_r));
            p10_r <= sat32(66'(p10_r) - 66'(t_r));
            p11_r <= sat32(66'(p11_r) + rshr16(prod));
          end
          OP_DIVGO1: k0_r <= quo;
          OP_Y:     begin k1_r <= quo; y_r <= sat32(66'(meas_r) - 66'(ang_r)); end
          OP_ANGC:  ang_r <= sat32(66'(ang_r) + rshr24(prod));
          OP_BIASC: bias_r <= sat32(66'(bias_r) + rshr24(prod));
          OP_C00:   p00_r <= sat32(66'(p00_r) - rshr24(prod));
          OP_C01:   p01_r <= sat32(66'(p01_r) - rshr24(prod));
          OP_C10:   p10_r <= sat32(66'(p10_r) - rshr24(prod));
          OP_C11:   p11_r <= sat32(66'(p11_r) - rshr24(prod));
          OP_CLEAR: begin p00_r <= '0; p01_r <= '0; p10_r <= '0; p11_r <= '0; end
          default:  ;
        endcase
      end
    end
  end

  assign sts.div_busy = dbusy;
  assign angle_q = ang_r;
  assign bias_q  = bias_r;
endmodule
`default_nettype wire

[rtl/kabe_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// kabe_ctrl
// Sequencer: steps the datapath through predict, gain, correct, update.
// ----------------------------------------------------------------------------
module kabe_ctrl
  import kabe_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    start,
  input  wire logic    clear,
  input  wire dp_sts_t sts,
  input  wire logic    out_ready,
  output dp_cmd_t      cmd,
  output logic         idle,
  output logic         out_valid
);
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RUN  = 5'b00010,
    S_DIV  = 5'b00100,
    S_WAIT = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;

  always_comb begin
    state_nxt = state_r; op_nxt = op_r;
    cmd.load = 1'b0; cmd.op = op_r;
    unique case (state_r)
      S_IDLE: if (start) begin
        state_nxt = S_RUN;
        op_nxt = clear ? OP_CLEAR : OP_RATE;
      end
      S_RUN: begin
        cmd.load = 1'b1;
        priority case (op_r)
          OP_CLEAR, OP_C01: state_nxt = S_OUT;
          OP_DIVGO0, OP_DIVGO1: state_nxt = S_DIV;
          default: op_nxt = op_t'(op_r + 4'd1);
        endcase
      end
      S_DIV: state_nxt = S_WAIT;
      S_WAIT: if (!sts.div_busy) begin
        state_nxt = S_RUN;
        op_nxt = op_t'(op_r + 4'd1);
      end
      S_OUT: if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= OP_NONE;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end

  assign idle      = state_r == S_IDLE;
  assign out_valid = state_r == S_OUT;
endmodule
`default_nettype wire
